### hw/rtl/vppe_pkg.sv
// ----------------------------------------------------------------------------
// Velocity profile evaluator package
// Shared constants, codes and the control and status types between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package vppe_pkg;

    localparam int LAST_POINT_INDEX = 15;
    localparam int TABLE_DEPTH      = LAST_POINT_INDEX + 1;
    localparam int DIV_STEPS        = 64;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_COUNT  = 2'd1;
    localparam logic [1:0] ST_DECREASING = 2'd2;
    localparam logic [1:0] ST_RANGE      = 2'd3;

    localparam logic CFG_INITIAL_POSITION = 1'b0;
    localparam logic CFG_POINT_COUNT      = 1'b1;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_WRITE,
        CMD_START,
        CMD_BADCNT,
        CMD_SCAN,
        CMD_RANGE,
        CMD_PREV,
        CMD_WALK,
        CMD_MUL,
        CMD_ACC,
        CMD_ADIV_LOAD,
        CMD_DIV,
        CMD_ASET,
        CMD_VEND,
        CMD_VMUL,
        CMD_VDIV_LOAD,
        CMD_VSET,
        CMD_XACC,
        CMD_OUT
    } cmd_e_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_RANGE,
        S_PREV,
        S_WALK,
        S_MUL1,
        S_ACC,
        S_SEGA,
        S_ADIV,
        S_ASET,
        S_VEND,
        S_VMUL,
        S_MUL2,
        S_VDIVL,
        S_VDIV,
        S_VSET,
        S_MUL3,
        S_XACC,
        S_OUT
    } state_t;

    typedef struct packed {
        logic bad_count;
        logic last;
        logic range_err;
        logic brk;
        logic dt_zero;
        logic div_done;
        logic end_case;
        logic out_free;
    } dp_stat_t;

endpackage

### hw/rtl/vppe_ctrl.sv
// ----------------------------------------------------------------------------
// Velocity profile evaluator controller
// Sequences table scans, segment walk, multiplications and divisions.
// ----------------------------------------------------------------------------
module vppe_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_mode,
    output logic              in_ready,
    input  vppe_pkg::dp_stat_t stat,
    output vppe_pkg::cmd_e_t  cmd
);

    vppe_pkg::state_t state_reg;
    vppe_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vppe_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vppe_pkg::S_IDLE:
            begin
                if (in_valid && in_mode == vppe_pkg::MODE_QUERY)
                begin
                    state_next = vppe_pkg::S_CHECK;
                end
            end
            vppe_pkg::S_CHECK:
            begin
                state_next = stat.bad_count ? vppe_pkg::S_OUT : vppe_pkg::S_SCAN;
            end
            vppe_pkg::S_SCAN:
            begin
                if (stat.last)
                begin
                    state_next = vppe_pkg::S_RANGE;
                end
            end
            vppe_pkg::S_RANGE:
            begin
                state_next = stat.range_err ? vppe_pkg::S_OUT : vppe_pkg::S_PREV;
            end
            vppe_pkg::S_PREV:  state_next = vppe_pkg::S_WALK;
            vppe_pkg::S_WALK:
            begin
                state_next = stat.brk ? vppe_pkg::S_SEGA : vppe_pkg::S_MUL1;
            end
            vppe_pkg::S_MUL1:  state_next = vppe_pkg::S_ACC;
            vppe_pkg::S_ACC:
            begin
                state_next = stat.last ? vppe_pkg::S_SEGA : vppe_pkg::S_WALK;
            end
            vppe_pkg::S_SEGA:
            begin
                state_next = stat.dt_zero ? vppe_pkg::S_ASET : vppe_pkg::S_ADIV;
            end
            vppe_pkg::S_ADIV:
            begin
                if (stat.div_done)
                begin
                    state_next = vppe_pkg::S_ASET;
                end
            end
            vppe_pkg::S_ASET:
            begin
                state_next = stat.end_case ? vppe_pkg::S_VEND : vppe_pkg::S_VMUL;
            end
            vppe_pkg::S_VEND:  state_next = vppe_pkg::S_OUT;
            vppe_pkg::S_VMUL:  state_next = vppe_pkg::S_MUL2;
            vppe_pkg::S_MUL2:  state_next = vppe_pkg::S_VDIVL;
            vppe_pkg::S_VDIVL: state_next = vppe_pkg::S_VDIV;
            vppe_pkg::S_VDIV:
            begin
                if (stat.div_done)
                begin
                    state_next = vppe_pkg::S_VSET;
                end
            end
            vppe_pkg::S_VSET:  state_next = vppe_pkg::S_MUL3;
            vppe_pkg::S_MUL3:  state_next = vppe_pkg::S_XACC;
            vppe_pkg::S_XACC:  state_next = vppe_pkg::S_OUT;
            vppe_pkg::S_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = vppe_pkg::S_IDLE;
                end
            end
            default: state_next = vppe_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = vppe_pkg::CMD_NONE;
        unique case (state_reg)
            vppe_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd = (in_mode == vppe_pkg::MODE_QUERY) ? vppe_pkg::CMD_START
                                                            : vppe_pkg::CMD_WRITE;
                end
            end
            vppe_pkg::S_CHECK:
            begin
                if (stat.bad_count)
                begin
                    cmd = vppe_pkg::CMD_BADCNT;
                end
            end
            vppe_pkg::S_SCAN:  cmd = vppe_pkg::CMD_SCAN;
            vppe_pkg::S_RANGE: cmd = vppe_pkg::CMD_RANGE;
            vppe_pkg::S_PREV:  cmd = vppe_pkg::CMD_PREV;
            vppe_pkg::S_WALK:  cmd = vppe_pkg::CMD_WALK;
            vppe_pkg::S_MUL1:  cmd = vppe_pkg::CMD_MUL;
            vppe_pkg::S_ACC:   cmd = vppe_pkg::CMD_ACC;
            vppe_pkg::S_SEGA:  cmd = vppe_pkg::CMD_ADIV_LOAD;
            vppe_pkg::S_ADIV:
            begin
                if (!stat.div_done)
                begin
                    cmd = vppe_pkg::CMD_DIV;
                end
            end
            vppe_pkg::S_ASET:  cmd = vppe_pkg::CMD_ASET;
            vppe_pkg::S_VEND:  cmd = vppe_pkg::CMD_VEND;
            vppe_pkg::S_VMUL:  cmd = vppe_pkg::CMD_VMUL;
            vppe_pkg::S_MUL2:  cmd = vppe_pkg::CMD_MUL;
            vppe_pkg::S_VDIVL: cmd = vppe_pkg::CMD_VDIV_LOAD;
            vppe_pkg::S_VDIV:
            begin
                if (!stat.div_done)
                begin
                    cmd = vppe_pkg::CMD_DIV;
                end
            end
            vppe_pkg::S_VSET:  cmd = vppe_pkg::CMD_VSET;
            vppe_pkg::S_MUL3:  cmd = vppe_pkg::CMD_MUL;
            vppe_pkg::S_XACC:  cmd = vppe_pkg::CMD_XACC;
            vppe_pkg::S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd = vppe_pkg::CMD_OUT;
                end
            end
            default: cmd = vppe_pkg::CMD_NONE;
        endcase
    end

endmodule

### hw/rtl/vppe_dp.sv
// ----------------------------------------------------------------------------
// Velocity profile evaluator datapath
// Breakpoint tables, configuration, shared multiplier, bit-serial divider,
// position accumulator and output register.
// ----------------------------------------------------------------------------
module vppe_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  vppe_pkg::cmd_e_t    cmd,
    input  logic [3:0]          point_index,
    input  logic signed [31:0]  point_time,
    input  logic signed [31:0]  point_velocity,
    input  logic signed [31:0]  query_time,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [47:0]         cfg_data,
    output vppe_pkg::dp_stat_t  stat,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          status,
    output logic signed [47:0]  position,
    output logic signed [31:0]  velocity,
    output logic signed [31:0]  acceleration
);

    logic signed [31:0] time_tab_reg [vppe_pkg::TABLE_DEPTH];
    logic signed [31:0] vel_tab_reg  [vppe_pkg::TABLE_DEPTH];
    logic signed [47:0] init_pos_reg;
    logic [7:0]         count_reg;

    logic [3:0]         idx_reg;
    logic signed [31:0] tq_reg;
    logic signed [31:0] t0_reg;
    logic signed [31:0] tlast_reg;
    logic               decr_reg;
    logic               end_reg;
    logic [1:0]         st_reg;
    logic signed [31:0] pt_reg;
    logic signed [31:0] pv_reg;
    logic signed [31:0] ct_reg;
    logic signed [31:0] cv_reg;
    logic [32:0]        ma_reg;
    logic [31:0]        mb_reg;
    logic               mneg_reg;
    logic [63:0]        prod_reg;
    logic signed [63:0] x_reg;
    logic [63:0]        num_reg;
    logic [32:0]        rem_reg;
    logic [31:0]        den_reg;
    logic [6:0]         cnt_reg;
    logic               dneg_reg;
    logic               dzero_reg;
    logic signed [31:0] vel_reg;
    logic signed [31:0] acc_reg;

    logic               out_valid_reg;
    logic [1:0]         out_status_reg;
    logic signed [47:0] out_pos_reg;
    logic signed [31:0] out_vel_reg;
    logic signed [31:0] out_acc_reg;

    logic signed [31:0] rd_t;
    logic signed [31:0] rd_v;
    logic               last;
    logic signed [32:0] wsum;
    logic signed [32:0] wdt;
    logic signed [32:0] dv;
    logic [32:0]        dv_mag;
    logic signed [32:0] dt_full;
    logic [31:0]        dt;
    logic signed [32:0] tau_full;
    logic [63:0]        p_lo;
    logic [63:0]        prod_next;
    logic [64:0]        rnd_sum;
    logic [47:0]        area_mag;
    logic signed [63:0] area;
    logic [32:0]        div_sh;
    logic               div_ge;
    logic signed [33:0] vel_wide;
    logic signed [32:0] vsum;
    logic signed [31:0] acc_sat;
    logic signed [47:0] pos_sat;
    logic               range_err;

    always_comb
    begin
        rd_t      = time_tab_reg[idx_reg];
        rd_v      = vel_tab_reg[idx_reg];
        last      = ({4'd0, idx_reg} == (count_reg - 8'd1));
        wsum      = 33'(rd_v) + 33'(pv_reg);
        wdt       = 33'(rd_t) - 33'(pt_reg);
        dv        = 33'(cv_reg) - 33'(pv_reg);
        dv_mag    = dv[32] ? 33'(-dv) : 33'(dv);
        dt_full   = 33'(ct_reg) - 33'(pt_reg);
        dt        = dt_full[31:0];
        tau_full  = 33'(tq_reg) - 33'(pt_reg);
        p_lo      = ma_reg[31:0] * mb_reg;
        prod_next = p_lo + (ma_reg[32] ? {mb_reg, 32'd0} : 64'd0);
        rnd_sum   = {1'b0, prod_reg} + 65'h10000;
        area_mag  = rnd_sum[64:17];
        area      = mneg_reg ? -64'(area_mag) : 64'(area_mag);
        div_sh    = {rem_reg[31:0], num_reg[63]};
        div_ge    = (div_sh >= {1'b0, den_reg});
        vel_wide  = 34'(pv_reg) + (dneg_reg ? -34'(num_reg[32:0]) : 34'(num_reg[32:0]));
        vsum      = 33'(pv_reg) + 33'($signed(vel_wide[31:0]));
        range_err = decr_reg || (tq_reg < t0_reg) || (tq_reg > tlast_reg);

        if (!dneg_reg)
        begin
            acc_sat = (num_reg > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(num_reg[31:0]);
        end
        else
        begin
            acc_sat = (num_reg > 64'h80000000) ? 32'sh80000000 : -$signed(num_reg[31:0]);
        end

        if (x_reg > 64'sh00007FFFFFFFFFFF)
        begin
            pos_sat = 48'sh7FFFFFFFFFFF;
        end
        else if (x_reg < -64'sh0000800000000000)
        begin
            pos_sat = 48'sh800000000000;
        end
        else
        begin
            pos_sat = x_reg[47:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < vppe_pkg::TABLE_DEPTH; i++)
            begin
                time_tab_reg[i] <= '0;
                vel_tab_reg[i]  <= '0;
            end
            init_pos_reg  <= '0;
            count_reg     <= 8'd2;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == vppe_pkg::CFG_INITIAL_POSITION)
                begin
                    init_pos_reg <= cfg_data;
                end
                else
                begin
                    count_reg <= cfg_data[7:0];
                end
            end

            if (cmd == vppe_pkg::CMD_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (cmd)
                vppe_pkg::CMD_WRITE:
                begin
                    time_tab_reg[point_index] <= point_time;
                    vel_tab_reg[point_index]  <= point_velocity;
                end
                vppe_pkg::CMD_START: idx_reg <= '0;
                vppe_pkg::CMD_SCAN:  idx_reg <= idx_reg + 4'd1;
                vppe_pkg::CMD_RANGE: idx_reg <= '0;
                vppe_pkg::CMD_PREV:  idx_reg <= idx_reg + 4'd1;
                vppe_pkg::CMD_ACC:
                begin
                    if (!last)
                    begin
                        idx_reg <= idx_reg + 4'd1;
                    end
                end
                vppe_pkg::CMD_ADIV_LOAD,
                vppe_pkg::CMD_VDIV_LOAD: cnt_reg <= 7'(vppe_pkg::DIV_STEPS);
                vppe_pkg::CMD_DIV:       cnt_reg <= cnt_reg - 7'd1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd == vppe_pkg::CMD_OUT)
        begin
            out_status_reg <= st_reg;
            out_pos_reg    <= (st_reg == vppe_pkg::ST_OK) ? pos_sat : '0;
            out_vel_reg    <= (st_reg == vppe_pkg::ST_OK) ? vel_reg : '0;
            out_acc_reg    <= (st_reg == vppe_pkg::ST_OK) ? acc_reg : '0;
        end

        unique case (cmd)
            vppe_pkg::CMD_START:
            begin
                tq_reg   <= query_time;
                decr_reg <= 1'b0;
                st_reg   <= vppe_pkg::ST_OK;
            end
            vppe_pkg::CMD_BADCNT: st_reg <= vppe_pkg::ST_BAD_COUNT;
            vppe_pkg::CMD_SCAN:
            begin
                if (idx_reg != '0 && rd_t < pt_reg)
                begin
                    decr_reg <= 1'b1;
                end
                if (idx_reg == '0)
                begin
                    t0_reg <= rd_t;
                end
                if (last)
                begin
                    tlast_reg <= rd_t;
                end
                pt_reg <= rd_t;
            end
            vppe_pkg::CMD_RANGE:
            begin
                if (decr_reg)
                begin
                    st_reg <= vppe_pkg::ST_DECREASING;
                end
                else if (range_err)
                begin
                    st_reg <= vppe_pkg::ST_RANGE;
                end
                x_reg   <= 64'(init_pos_reg);
                end_reg <= (tq_reg == tlast_reg);
            end
            vppe_pkg::CMD_PREV:
            begin
                pt_reg <= rd_t;
                pv_reg <= rd_v;
            end
            vppe_pkg::CMD_WALK:
            begin
                ct_reg   <= rd_t;
                cv_reg   <= rd_v;
                ma_reg   <= wsum[32] ? 33'(-wsum) : 33'(wsum);
                mneg_reg <= wsum[32];
                mb_reg   <= wdt[31:0];
            end
            vppe_pkg::CMD_MUL: prod_reg <= prod_next;
            vppe_pkg::CMD_ACC:
            begin
                x_reg <= x_reg + area;
                if (!last)
                begin
                    pt_reg <= ct_reg;
                    pv_reg <= cv_reg;
                end
            end
            vppe_pkg::CMD_ADIV_LOAD:
            begin
                num_reg   <= {15'd0, dv_mag, 16'd0} + {33'd0, dt[31:1]};
                den_reg   <= dt;
                rem_reg   <= '0;
                dneg_reg  <= dv[32];
                dzero_reg <= (dt == '0);
            end
            vppe_pkg::CMD_DIV:
            begin
                rem_reg <= div_ge ? (div_sh - {1'b0, den_reg}) : div_sh;
                num_reg <= {num_reg[62:0], div_ge};
            end
            vppe_pkg::CMD_ASET: acc_reg <= dzero_reg ? 32'sd0 : acc_sat;
            vppe_pkg::CMD_VEND: vel_reg <= cv_reg;
            vppe_pkg::CMD_VMUL:
            begin
                ma_reg <= dv_mag;
                mb_reg <= tau_full[31:0];
            end
            vppe_pkg::CMD_VDIV_LOAD:
            begin
                num_reg <= prod_reg + {33'd0, dt[31:1]};
                den_reg <= dt;
                rem_reg <= '0;
            end
            vppe_pkg::CMD_VSET:
            begin
                vel_reg  <= vel_wide[31:0];
                ma_reg   <= vsum[32] ? 33'(-vsum) : 33'(vsum);
                mneg_reg <= vsum[32];
                mb_reg   <= tau_full[31:0];
            end
            vppe_pkg::CMD_XACC: x_reg <= x_reg + area;
            default: ;
        endcase
    end

    always_comb
    begin
        stat.bad_count = (count_reg < 8'd2) || (count_reg > 8'(vppe_pkg::TABLE_DEPTH));
        stat.last      = last;
        stat.range_err = range_err;
        stat.brk       = !end_reg && (tq_reg < rd_t);
        stat.dt_zero   = (dt == '0);
        stat.div_done  = (cnt_reg == '0);
        stat.end_case  = end_reg;
        stat.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign position     = out_pos_reg;
    assign velocity     = out_vel_reg;
    assign acceleration = out_acc_reg;

endmodule

### hw/rtl/velocity_profile_point_evaluator.sv
// ----------------------------------------------------------------------------
// Velocity profile point evaluator
// Piecewise linear velocity profile held as up to sixteen breakpoints.
// ----------------------------------------------------------------------------
// A transfer on the input stream with tuser low writes one breakpoint and
// gives no result. With tuser high it queries the profile at query_time and
// gives one result transfer carrying status, position, velocity and
// acceleration; an error status carries zero outputs.
// The registers initial_position and point_count are to be written on the cfg
// port only while the block is idle; the block itself does not enforce this.
// A query whose time lies inside a segment passes through the order and range
// checks, a walk over the segments before it and two bit-serial divisions,
// one for the acceleration and one for the velocity. A query at the end time
// walks every segment and needs at most one division. A bad point count
// returns right after the count check, a decreasing table or an out-of-range
// time after the order and range checks. The divider gives one quotient bit
// per cycle, and the next input can be taken in the same cycle that the
// result is presented.
// Only one query is in flight. A finished result sits in the output register,
// and a further write item is still taken while that result is stalled.
// Reset clears the breakpoint tables to zero, sets initial_position to zero
// and point_count to two, and empties the output register.
// ----------------------------------------------------------------------------
module velocity_profile_point_evaluator (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // point_index[3:0], point_time[35:4], point_velocity[67:36],
    // query_time[99:68], zero fill
    input  logic [103:0] s_axis_tdata,
    // mode
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0], position[49:2], velocity[81:50], acceleration[113:82],
    // zero fill
    output logic [119:0] m_axis_tdata,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [47:0]  cfg_data
);

    vppe_pkg::cmd_e_t   cmd;
    vppe_pkg::dp_stat_t stat;
    logic [1:0]         status;
    logic signed [47:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] acceleration;

    vppe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_mode  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    vppe_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .point_index    (s_axis_tdata[3:0]),
        .point_time     (s_axis_tdata[35:4]),
        .point_velocity (s_axis_tdata[67:36]),
        .query_time     (s_axis_tdata[99:68]),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .stat           (stat),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .status         (status),
        .position       (position),
        .velocity       (velocity),
        .acceleration   (acceleration)
    );

    assign m_axis_tdata = {6'd0, acceleration, velocity, position, status};

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Velocity profile point evaluator testbench
// Loads breakpoint tables over the input stream, sets the registers while the
// block is idle and queries the profile at directed and random times. A
// scoreboard predicts each query result and checks every output transfer.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import vppe_pkg::*;

    typedef struct {
        logic [1:0]  status;
        logic [47:0] position;
        logic [31:0] velocity;
        logic [31:0] acceleration;
    } profile_result_t;

    class profile_scoreboard;
        longint          time_tab[TABLE_DEPTH];
        longint          vel_tab[TABLE_DEPTH];
        longint          start_pos;
        int unsigned     n_points;
        profile_result_t expected_q[$];
        int              mismatches;

        function new();
            foreach (time_tab[i])
            begin
                time_tab[i] = 0;
                vel_tab[i]  = 0;
            end
            start_pos  = 0;
            n_points   = 2;
            mismatches = 0;
        endfunction

        function void set_register(logic idx, logic [47:0] value);
            if (idx == CFG_INITIAL_POSITION)
                start_pos = longint'(signed'(value));
            else
                n_points = value[7:0];
        endfunction

        function longint unsigned magnitude(longint v);
            return v < 0 ? longint'(0) - v : v;
        endfunction

        function longint area(longint vsum, longint unsigned dur);
            longint unsigned p;
            longint          r;
            p = magnitude(vsum) * dur;
            r = longint'((p + 64'd65536) >> 17);
            return vsum < 0 ? -r : r;
        endfunction

        function longint rounded_div(longint num, longint unsigned scaled,
                                     longint unsigned den);
            longint q;
            q = longint'((scaled + den / 2) / den);
            return num < 0 ? -q : q;
        endfunction

        function longint slope(longint dv, longint unsigned dt);
            longint a;
            if (dt == 0)
                return 0;
            a = rounded_div(dv, magnitude(dv) << 16, dt);
            if (a > 64'sd2147483647)
                a = 64'sd2147483647;
            if (a < -64'sd2147483648)
                a = -64'sd2147483648;
            return a;
        endfunction

        function void note_input(logic mode, logic [3:0] idx, logic [31:0] t,
                                 logic [31:0] v, logic [31:0] qt);
            profile_result_t r;
            longint          tq, x, vel, acc, tau, dv;
            longint unsigned dt;
            int unsigned     seg;
            logic [1:0]      st;
            if (mode == MODE_WRITE)
            begin
                time_tab[idx] = longint'(signed'(t));
                vel_tab[idx]  = longint'(signed'(v));
                return;
            end
            tq  = longint'(signed'(qt));
            x   = 0;
            vel = 0;
            acc = 0;
            st  = ST_OK;
            if (n_points < 2 || n_points > TABLE_DEPTH)
            begin
                st = ST_BAD_COUNT;
            end
            else
            begin
                for (int i = 1; i < n_points; i++)
                    if (time_tab[i] < time_tab[i-1])
                        st = ST_DECREASING;
                if (st == ST_OK && (tq < time_tab[0] || tq > time_tab[n_points-1]))
                    st = ST_RANGE;
            end
            if (st == ST_OK)
            begin
                x = start_pos;
                if (tq == time_tab[n_points-1])
                begin
                    for (int i = 1; i < n_points; i++)
                        x += area(vel_tab[i] + vel_tab[i-1], time_tab[i] - time_tab[i-1]);
                    vel = vel_tab[n_points-1];
                    acc = slope(vel_tab[n_points-1] - vel_tab[n_points-2],
                                time_tab[n_points-1] - time_tab[n_points-2]);
                end
                else
                begin
                    seg = 0;
                    for (int i = 1; i < n_points; i++)
                    begin
                        if (tq < time_tab[i])
                        begin
                            seg = i - 1;
                            break;
                        end
                        x += area(vel_tab[i] + vel_tab[i-1], time_tab[i] - time_tab[i-1]);
                    end
                    dv  = vel_tab[seg+1] - vel_tab[seg];
                    dt  = time_tab[seg+1] - time_tab[seg];
                    tau = tq - time_tab[seg];
                    acc = slope(dv, dt);
                    vel = vel_tab[seg] + rounded_div(dv, magnitude(dv) * tau, dt);
                    x  += area(vel_tab[seg] + vel, tau);
                end
                if (x > 64'sh7FFFFFFFFFFF)
                    x = 64'sh7FFFFFFFFFFF;
                if (x < -64'sh800000000000)
                    x = -64'sh800000000000;
            end
            r.status       = st;
            r.position     = x[47:0];
            r.velocity     = vel[31:0];
            r.acceleration = acc[31:0];
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [119:0] d);
            profile_result_t e;
            if (expected_q.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result transfer: %h", d);
                mismatches++;
                return;
            end
            e = expected_q.pop_front();
            if (d[1:0] !== e.status || d[49:2] !== e.position ||
                d[81:50] !== e.velocity || d[113:82] !== e.acceleration)
            begin
                if (mismatches < 10)
                    $display({"result mismatch: expected st %0d x %h v %h a %h, ",
                              "got st %0d x %h v %h a %h"},
                             e.status, e.position, e.velocity, e.acceleration,
                             d[1:0], d[49:2], d[81:50], d[113:82]);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [119:0] m_axis_tdata;
    logic         cfg_we = 1'b0;
    logic         cfg_index = 1'b0;
    logic [47:0]  cfg_data = '0;

    profile_scoreboard sb = new();
    int  items_sent = 0;
    bit  hold_output = 1'b0;
    bit  stimulus_done = 1'b0;
    int  table_n;
    int  tq_list[$];

    always #4 clk = ~clk;

    velocity_profile_point_evaluator i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    task automatic send_item(logic mode, logic [3:0] idx, logic [31:0] t,
                             logic [31:0] v, logic [31:0] qt);
        int gap;
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {4'b0, qt, v, t, idx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_input(mode, idx, t, v, qt);
        items_sent++;
    endtask

    task automatic write_point(logic [3:0] idx, int t, int v);
        send_item(MODE_WRITE, idx, t, v, $urandom);
    endtask

    task automatic query(int qt);
        send_item(MODE_QUERY, 4'($urandom), $urandom, $urandom, qt);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic set_registers(logic [47:0] pos, logic [7:0] count);
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        cfg_we    <= 1'b1;
        cfg_index <= CFG_INITIAL_POSITION;
        cfg_data  <= pos;
        @(posedge clk);
        sb.set_register(CFG_INITIAL_POSITION, pos);
        cfg_index <= CFG_POINT_COUNT;
        cfg_data  <= {noise[47:8], count};
        @(posedge clk);
        sb.set_register(CFG_POINT_COUNT, {noise[47:8], count});
        cfg_we <= 1'b0;
    endtask

    // Random 48-bit start position with the extremes now and then.
    function automatic logic [47:0] pick_position();
        case ($urandom_range(0, 5))
            0: return 48'h7FFF_FFFF_FFFF;
            1: return 48'h8000_0000_0000;
            2: return {{16{1'b0}}, $urandom} >> $urandom_range(0, 16);
            default: return 48'({$urandom, $urandom});
        endcase
    endfunction

    function automatic int pick_query();
        longint lo, hi, span;
        lo = tq_list[0];
        hi = tq_list[table_n - 1];
        span = hi - lo;
        case ($urandom_range(0, 9))
            0: return tq_list[table_n - 1];
            1: return tq_list[$urandom_range(0, table_n - 1)];
            2: return $urandom;
            default:
                if (span <= 0)
                    return int'(lo);
                else
                    return int'(lo + longint'({$urandom, $urandom} % (span + 1)));
        endcase
    endfunction

    always
    begin : receiver
        int stall;
        stall = $urandom_range(0, 9);
        if ($urandom_range(0, 2) == 0)
            stall = 0;
        if (hold_output)
        begin
            m_axis_tready <= 1'b0;
            repeat (1500) @(posedge clk);
            hold_output = 1'b0;
        end
        else if (stall > 0)
        begin
            m_axis_tready <= 1'b0;
            repeat (stall) @(posedge clk);
        end
        m_axis_tready <= 1'b1;
        do
            @(posedge clk);
        while (!m_axis_tvalid);
        sb.check_result(m_axis_tdata);
    end

    initial
    begin : stimulus
        int phase;
        int scale;
        int v;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset table: both points at time zero, so zero is the end time.
        query(0);
        query(1);
        write_point(4'd0, 32'h8000_0000, 32'h8000_0000);
        write_point(4'd1, 0, 32'h7FFF_FFFF);
        write_point(4'd2, 0, 0);
        write_point(4'd3, 32'h7FFF_FFFF, 32'h8000_0000);
        wait_idle();
        set_registers(48'h7FFF_FFFF_FFFF, 8'd4);
        query(32'h8000_0000);
        query(-100);
        query(0);
        query(32'h7FFF_FFFF);
        query(32'h7FFF_0000);
        wait_idle();
        set_registers(48'h8000_0000_0000, 8'd16);
        query(0);
        wait_idle();
        set_registers(48'd0, 8'd1);
        query(0);
        wait_idle();
        set_registers(48'd0, 8'd17);
        query(0);
        wait_idle();
        set_registers(48'd0, 8'd255);
        query(0);
        wait_idle();
        set_registers(48'd0, 8'd0);
        query(0);
        write_point(4'd15, 32'h7FFF_FFFF, 32'h7FFF_FFFF);

        phase = 0;
        while (items_sent < 1450)
        begin
            table_n = $urandom_range(2, TABLE_DEPTH);
            if ($urandom_range(0, 3) == 0)
                table_n = $urandom_range(2, 3);
            scale = $urandom_range(0, 2);
            tq_list.delete();
            for (int i = 0; i < table_n; i++)
            begin
                if (scale == 0)
                    tq_list.push_back($urandom);
                else if (scale == 1)
                    tq_list.push_back($urandom_range(0, 4000) * 16 - 32000);
                else
                    tq_list.push_back($urandom_range(0, 40) << 16);
            end
            tq_list.sort();
            if ($urandom_range(0, 9) == 0 && table_n > 2)
                tq_list[1] = tq_list[table_n - 1] + 1;
            for (int i = 0; i < table_n; i++)
            begin
                v = (scale == 0) ? $urandom : $urandom_range(0, 200000) - 100000;
                if ($urandom_range(0, 15) == 0)
                    v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                write_point(4'(i), tq_list[i], v);
            end
            if ($urandom_range(0, 3) == 0)
                write_point(4'($urandom_range(table_n, 15)), $urandom, $urandom);
            wait_idle();
            if ($urandom_range(0, 12) == 0)
                set_registers(pick_position(), 8'($urandom_range(0, 255)));
            else if ($urandom_range(0, 12) == 0)
                set_registers(pick_position(), $urandom_range(0, 1) ? 8'd0 : 8'd17);
            else
                set_registers(pick_position(), 8'(table_n));
            if (phase == 3)
                hold_output = 1'b1;
            repeat ($urandom_range(2, 12))
                query(pick_query());
            phase++;
        end
        wait_idle();
        repeat (250) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("velocity_profile_point_evaluator: match");
        else
            $display("velocity_profile_point_evaluator: mismatch");
        $finish;
    end

    initial
    begin : watchdog
        #20ms;
        $display("velocity_profile_point_evaluator: mismatch");
        $finish;
    end

endmodule
